[design/cds_pkg.sv]
package cds_pkg;

    localparam logic [1:0] ACT_DAYS   = 2'd0;
    localparam logic [1:0] ACT_MONTHS = 2'd1;
    localparam logic [1:0] ACT_YEARS  = 2'd2;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [4:0] DAY_FEB_LEAP = 5'd29;
    localparam logic [4:0] DAY_FEB_NORM = 5'd28;

    // 25 * INV25 == 1 mod 2^16; x divisible by 25 iff x * INV25 mod 2^16 <= 65535 / 25
    localparam logic [15:0] INV25     = 16'h5C29;
    localparam logic [15:0] DIV25_LIM = 16'd2621;

    typedef struct packed {
        logic load;
        logic clamp;
        logic step;
        logic ysub;
        logic fix;
        logic emit;
    } cds_cmd_t;

    typedef struct packed {
        logic       cnt_zero;
        logic [1:0] action;
        logic       out_stall;
    } cds_status_t;

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2:                   len = leap ? DAY_FEB_LEAP : DAY_FEB_NORM;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[design/cds_ctrl.sv]
module cds_ctrl
    import cds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  cds_status_t status,
    output cds_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETTLE = 3'd1;
    localparam logic [2:0] ST_CLAMP  = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_YSUB   = 3'd4;
    localparam logic [2:0] ST_YWAIT  = 3'd5;
    localparam logic [2:0] ST_FIX    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: state_next = ST_CLAMP;
            ST_CLAMP: begin
                cmd.clamp = 1'b1;
                priority if (status.action == ACT_DAYS || status.action == ACT_MONTHS) begin
                    state_next = ST_RUN;
                end else if (status.action == ACT_YEARS) begin
                    state_next = ST_YSUB;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN: begin
                if (status.cnt_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_YSUB: begin
                cmd.ysub   = 1'b1;
                state_next = ST_YWAIT;
            end
            ST_YWAIT: state_next = ST_FIX;
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_stall) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/cds_dp.sv]
module cds_dp
    import cds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [47:0] s_tdata,
    input  cds_cmd_t    cmd,
    output cds_status_t status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    logic [1:0]  action_reg;
    logic [15:0] cnt_reg;
    logic [15:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic        leap_reg;
    logic [15:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic        out_valid_reg;

    logic [1:0]  in_action;
    logic [15:0] in_amount;
    logic [15:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [3:0]  month_sat;
    logic [4:0]  day_sat;

    logic [15:0] mag;
    logic [15:0] prod;
    logic        leap_next;

    logic [3:0]  prev_month;
    logic [15:0] prev_year;
    logic [4:0]  prev_len;
    logic [4:0]  cur_len;

    assign in_action = s_tdata[1:0];
    assign in_amount = s_tdata[17:2];
    assign in_year   = s_tdata[33:18];
    assign in_month  = s_tdata[37:34];
    assign in_day    = s_tdata[42:38];

    assign month_sat = (in_month == 4'd0) ? MON_JAN : ((in_month > MON_DEC) ? MON_DEC : in_month);
    assign day_sat   = (in_day == 5'd0) ? 5'd1 : in_day;

    // leap rule on |year|: div by 4, and not by 100 unless by 400
    assign mag       = year_reg[15] ? (16'd0 - year_reg) : year_reg;
    assign prod      = 16'(mag * INV25);
    assign leap_next = (mag[1:0] == 2'd0) && ((prod > DIV25_LIM) || (mag[3:0] == 4'd0));

    assign prev_month = (month_reg == MON_JAN) ? MON_DEC : (month_reg - 4'd1);
    assign prev_year  = (month_reg == MON_JAN) ? (year_reg - 16'd1) : year_reg;
    assign prev_len   = days_in(prev_month, leap_reg);
    assign cur_len    = days_in(month_reg, leap_reg);

    always_ff @(posedge aclk) begin
        leap_reg <= leap_next;
        if (cmd.load) begin
            action_reg <= in_action;
            cnt_reg    <= in_amount;
            year_reg   <= in_year;
            month_reg  <= month_sat;
            day_reg    <= day_sat;
        end else if (cmd.clamp) begin
            if (day_reg > cur_len) begin
                day_reg <= cur_len;
            end
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg - 16'd1;
            if (action_reg == ACT_DAYS && day_reg > 5'd1) begin
                day_reg <= day_reg - 5'd1;
            end else begin
                month_reg <= prev_month;
                year_reg  <= prev_year;
                if (action_reg == ACT_DAYS || day_reg > prev_len) begin
                    day_reg <= prev_len;
                end
            end
        end else if (cmd.ysub) begin
            year_reg <= year_reg - cnt_reg;
        end else if (cmd.fix) begin
            if (month_reg == MON_FEB && day_reg == DAY_FEB_LEAP && !leap_reg) begin
                day_reg <= DAY_FEB_NORM;
            end
        end
        if (cmd.emit) begin
            out_year_reg  <= year_reg;
            out_month_reg <= month_reg;
            out_day_reg   <= day_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.cnt_zero  = (cnt_reg == 16'd0);
    assign status.action    = action_reg;
    assign status.out_stall = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_day_reg, out_month_reg, out_year_reg};

endmodule

[design/calendar_date_subtractor_top.sv]
// Gregorian date subtractor.
// Slave stream carries one request: action, amount and a start date. Master
// stream returns the date moved back by the amount.
// Days and months are stepped back one unit per cycle by a counter loop,
// while years are subtracted from the year field directly. The leap flag is
// registered from the current year and settles in the cycle after each year
// load or subtraction.
// One request is in flight at a time; s_tready rises again at the same edge
// that moves the result into the output register, so the next request can be
// taken while that result still waits.
// If m_tready stays low the result holds in the output register and the
// following request completes its loop, then waits until the slot frees.
// Reset (aresetn low, synchronous) drops m_tvalid and returns to idle.
module calendar_date_subtractor_top
    import cds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // action[1:0], amount[17:2], in_year[33:18],
                                  // in_month[37:34], in_day[42:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // out_year[15:0], out_month[19:16], out_day[24:20]
);

    cds_cmd_t    cmd;
    cds_status_t status;

    cds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cds_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[design/cds_checker.sv]
module cds_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:16] != 4'd0) && (m_tdata[19:16] < 4'd13)
                     && (m_tdata[24:20] != 5'd0))
        else $error("result date out of range");

endmodule

bind calendar_date_subtractor_top cds_checker u_cds_checker (.*);
